// File: sv/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer
// used by tcw_front, tcw_back and the top level; depends on nothing
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int POS_W  = 13;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int CELL_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  CHAR_BS    = 8'h08;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_NL    = 8'h0A;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [15:0] RESET_CELL = 16'h0F20;

    localparam logic [6:0] RESET_ROWS = 7'd25;
    localparam logic [7:0] RESET_COLS = 8'd80;
    localparam logic [7:0] RESET_ATTR = 8'h0F;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        REG_ROWS = 2'd0,
        REG_COLS = 2'd1,
        REG_ATTR = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        K_PRINT,
        K_BACK,
        K_TAB,
        K_NEWLINE,
        K_IGNORE,
        K_CLEAR,
        K_READ,
        K_NOP
    } t_kind;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCROLL_MUL,
        S_COPY,
        S_FILL
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  char_code;
        logic [12:0] cell_address;
        logic        in_store;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
        logic [CELL_W-1:0] read_cell;
    } t_res;

    typedef struct packed {
        logic [6:0] rows;
        logic [7:0] cols;
        logic [7:0] attr;
    } t_cfg;

endpackage

// File: sv/tcw_fifo.sv
// tcw_fifo: small synchronous queue for packed items
// used for the command queue and the result queue; no package needed
`timescale 1ns / 1ps

module tcw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/tcw_front.sv
// tcw_front: accepts input items and sorts them into engine commands
// depends on tcw_pkg; feeds the command queue
`timescale 1ns / 1ps

module tcw_front #(
    parameter int STORE_DEPTH = 8192
) (
    input  logic          i_push,
    input  logic [1:0]    i_opcode,
    input  logic [7:0]    i_char_code,
    input  logic [12:0]   i_cell_address,
    input  logic          i_init_busy,
    input  logic          i_cmd_full,
    output logic          o_full,
    output logic          o_cmd_push,
    output tcw_pkg::t_cmd o_cmd
);

    assign o_full     = i_init_busy || i_cmd_full;
    assign o_cmd_push = i_push && !o_full;

    always_comb begin
        o_cmd.char_code    = i_char_code;
        o_cmd.cell_address = i_cell_address;
        o_cmd.in_store     = (32'(i_cell_address) < 32'(STORE_DEPTH));
        case (i_opcode)
            tcw_pkg::OP_PUT: begin
                case (i_char_code)
                    tcw_pkg::CHAR_BS:  o_cmd.kind = tcw_pkg::K_BACK;
                    tcw_pkg::CHAR_TAB: o_cmd.kind = tcw_pkg::K_TAB;
                    tcw_pkg::CHAR_NL:  o_cmd.kind = tcw_pkg::K_NEWLINE;
                    default: begin
                        if (i_char_code inside {[tcw_pkg::CHAR_SPACE:8'hFF]}) begin
                            o_cmd.kind = tcw_pkg::K_PRINT;
                        end else begin
                            o_cmd.kind = tcw_pkg::K_IGNORE;
                        end
                    end
                endcase
            end
            tcw_pkg::OP_CLEAR: o_cmd.kind = tcw_pkg::K_CLEAR;
            tcw_pkg::OP_READ:  o_cmd.kind = tcw_pkg::K_READ;
            default:           o_cmd.kind = tcw_pkg::K_NOP;
        endcase
    end

endmodule

// File: sv/tcw_back.sv
// tcw_back: console engine with the screen memory, cursor and scroll/clear walker
// depends on tcw_pkg; takes commands from the command queue, pushes results
`timescale 1ns / 1ps

module tcw_back #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 128,
    parameter int TAB_WIDTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tcw_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output tcw_pkg::t_res o_res,
    output logic          o_init_busy
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CLW   = $clog2(MAX_COLS + 1);
    localparam int CTW   = $clog2(MAX_COLS + TAB_WIDTH + 1);
    localparam int PW    = RW + CLW;
    localparam int SW    = PW + 1;
    localparam int NSTOP = (MAX_COLS - 1) / TAB_WIDTH + 1;

    tcw_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_idx, n_idx;
    logic [RW-1:0]   r_row, n_row;
    logic [CLW-1:0]  r_col, n_col;
    logic            r_cp_valid, n_cp_valid;
    tcw_pkg::t_cmd   r_cmd, n_cmd;
    logic [PW-1:0]   r_prod, n_prod;
    logic [PW-1:0]   r_area, n_area;
    logic [PW-1:0]   r_off, n_off;
    logic [RW-1:0]   r_n, n_n;
    logic [PW-1:0]   r_cp_dst, n_cp_dst;
    tcw_pkg::t_res   r_res, n_res;

    logic [15:0]     r_screen [DEPTH];
    logic [15:0]     r_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;

    logic [RW-1:0]   rows_eff;
    logic [CLW-1:0]  cols_eff;
    logic [15:0]     blank;

    logic [CTW-1:0]  tab_stop;
    logic [CTW-1:0]  col_a;
    logic            is_nl;
    logic            wrap;
    logic            up;
    logic [CLW-1:0]  col_b;
    logic [RW-1:0]   row_b;
    logic            scroll;
    logic [RW-1:0]   n_lines;
    logic [SW-1:0]   pos_now;
    logic [SW-1:0]   pos_put;
    logic [SW-1:0]   pos_scr;
    logic [SW-1:0]   copy_src;
    tcw_pkg::t_res   res_now;

    // out-of-range sizes clamp to 1 and to the maximum
    always_comb begin
        if (i_cfg.rows == '0) begin
            rows_eff = RW'(1);
        end else if (32'(i_cfg.rows) > 32'(MAX_ROWS)) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(i_cfg.rows);
        end
        if (i_cfg.cols == '0) begin
            cols_eff = CLW'(1);
        end else if (32'(i_cfg.cols) > 32'(MAX_COLS)) begin
            cols_eff = CLW'(MAX_COLS);
        end else begin
            cols_eff = CLW'(i_cfg.cols);
        end
    end

    assign blank       = {i_cfg.attr, tcw_pkg::CHAR_SPACE};
    assign o_init_busy = (r_state == tcw_pkg::S_INIT);

    // cursor motion of a put, evaluated in the execute cycle
    always_comb begin
        tab_stop = CTW'(NSTOP * TAB_WIDTH);
        for (int k = NSTOP; k >= 1; k--) begin
            if (32'(r_col) < 32'(k * TAB_WIDTH)) begin
                tab_stop = CTW'(k * TAB_WIDTH);
            end
        end
        col_a = CTW'(r_col);
        is_nl = 1'b0;
        case (r_cmd.kind)
            tcw_pkg::K_PRINT: col_a = CTW'(r_col) + CTW'(1);
            tcw_pkg::K_BACK: begin
                if (r_col != '0) begin
                    col_a = CTW'(r_col) - CTW'(1);
                end
            end
            tcw_pkg::K_TAB: col_a = tab_stop;
            tcw_pkg::K_NEWLINE: begin
                col_a = '0;
                is_nl = 1'b1;
            end
            default: ;
        endcase
        wrap    = (col_a >= CTW'(cols_eff));
        up      = is_nl || wrap;
        col_b   = wrap ? '0 : CLW'(col_a);
        row_b   = up ? r_row + RW'(1) : r_row;
        scroll  = (row_b >= rows_eff);
        n_lines = row_b - rows_eff + RW'(1);
        pos_now = SW'(r_prod) + SW'(r_col);
        pos_put = SW'(r_prod) + (up ? SW'(cols_eff) : '0) + SW'(col_b);
        pos_scr = SW'(r_area) - SW'(cols_eff) + SW'(col_b);
    end

    assign copy_src = SW'(r_idx) + SW'(r_off);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_row      = r_row;
        n_col      = r_col;
        n_cp_valid = 1'b0;
        n_cmd      = r_cmd;
        n_prod     = r_prod;
        n_area     = r_area;
        n_off      = r_off;
        n_n        = r_n;
        n_cp_dst   = r_cp_dst;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = AW'(r_idx);
        mem_wdata  = blank;
        mem_raddr  = AW'(i_cmd.cell_address);
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_res;

        res_now.cursor_position = tcw_pkg::POS_W'(pos_now);
        res_now.cursor_column   = tcw_pkg::COL_W'(r_col);
        res_now.cursor_row      = tcw_pkg::ROW_W'(r_row);
        res_now.scrolled        = 1'b0;
        res_now.read_cell       = '0;

        case (r_state)
            tcw_pkg::S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = tcw_pkg::RESET_CELL;
                if (r_idx == PW'(DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = tcw_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + PW'(1);
                end
            end
            tcw_pkg::S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_prod    = PW'(r_row) * PW'(cols_eff);
                    n_area    = PW'(rows_eff) * PW'(cols_eff);
                    n_state   = tcw_pkg::S_EXEC;
                end
            end
            tcw_pkg::S_EXEC: begin
                n_state = tcw_pkg::S_IDLE;
                case (r_cmd.kind)
                    tcw_pkg::K_CLEAR: begin
                        n_row                   = '0;
                        n_col                   = '0;
                        res_now.cursor_position = '0;
                        res_now.cursor_column   = '0;
                        res_now.cursor_row      = '0;
                        n_res                   = res_now;
                        n_idx                   = '0;
                        n_state                 = tcw_pkg::S_FILL;
                    end
                    tcw_pkg::K_READ: begin
                        // memory was read at the item address during dispatch
                        res_now.read_cell = r_cmd.in_store ? r_rdata : '0;
                        o_res             = res_now;
                        o_res_push        = 1'b1;
                    end
                    tcw_pkg::K_NOP: begin
                        o_res      = res_now;
                        o_res_push = 1'b1;
                    end
                    default: begin
                        if (r_cmd.kind == tcw_pkg::K_PRINT && pos_now < SW'(DEPTH)) begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(pos_now);
                            mem_wdata = {i_cfg.attr, r_cmd.char_code};
                        end
                        res_now.cursor_column = tcw_pkg::COL_W'(col_b);
                        n_col                 = col_b;
                        if (scroll) begin
                            n_row                   = rows_eff - RW'(1);
                            res_now.cursor_position = tcw_pkg::POS_W'(pos_scr);
                            res_now.cursor_row      = tcw_pkg::ROW_W'(rows_eff - RW'(1));
                            res_now.scrolled        = 1'b1;
                            n_res                   = res_now;
                            n_n                     = n_lines;
                            n_idx                   = '0;
                            if (n_lines >= rows_eff) begin
                                n_state = tcw_pkg::S_FILL;
                            end else begin
                                n_state = tcw_pkg::S_SCROLL_MUL;
                            end
                        end else begin
                            n_row                   = row_b;
                            res_now.cursor_position = tcw_pkg::POS_W'(pos_put);
                            res_now.cursor_row      = tcw_pkg::ROW_W'(row_b);
                            o_res                   = res_now;
                            o_res_push              = 1'b1;
                        end
                    end
                endcase
            end
            tcw_pkg::S_SCROLL_MUL: begin
                n_off   = PW'(r_n) * PW'(cols_eff);
                n_idx   = '0;
                n_state = tcw_pkg::S_COPY;
            end
            tcw_pkg::S_COPY: begin
                // read runs one cell ahead of the write-back
                if (r_cp_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_cp_dst);
                    mem_wdata = r_rdata;
                end
                if (copy_src < SW'(r_area)) begin
                    mem_raddr  = AW'(copy_src);
                    n_cp_valid = 1'b1;
                    n_cp_dst   = r_idx;
                    n_idx      = r_idx + PW'(1);
                end else begin
                    n_state = tcw_pkg::S_FILL;
                end
            end
            tcw_pkg::S_FILL: begin
                if (r_idx < r_area) begin
                    mem_we = 1'b1;
                    n_idx  = r_idx + PW'(1);
                end else begin
                    o_res_push = 1'b1;
                    n_state    = tcw_pkg::S_IDLE;
                end
            end
            default: n_state = tcw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcw_pkg::S_INIT;
            r_idx      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_row      <= n_row;
            r_col      <= n_col;
            r_cp_valid <= n_cp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_prod   <= n_prod;
        r_area   <= n_area;
        r_off    <= n_off;
        r_n      <= n_n;
        r_cp_dst <= n_cp_dst;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_screen[mem_raddr];
    end

endmodule

// File: sv/text_console_writer_top.sv
// text_console_writer_top: text console writer top level
// depends on tcw_pkg, tcw_front, tcw_fifo and tcw_back
`timescale 1ns / 1ps

// Text-mode console: a screen memory of 16-bit cells (attribute, character) and a cursor.
// Input items (push/full): opcode put, clear or read, with a character and a cell address.
// Result items (empty/pop): cursor position, column and row after the item, a scroll
// flag and the cell read. Every input item gives exactly one result item, in order.
// Sizes and attribute sit in an APB register file at byte addresses 0, 4 and 8.
// Put, read and unused opcodes pass from the command queue through the engine's dispatch
// and execute states into the result queue; the engine takes one item at a time.
// A scroll walks the screen memory through its single read and write port: a multiply
// state, a copy pass that reads one cell ahead of its write-back, then a fill that blanks
// the freed rows; a full-screen scroll only fills. A clear blanks rows*cols cells.
// While the engine walks, items pile up in a 2-entry command queue, then full rises.
// After reset a clearing pass writes the blank reset cell to all MAX_ROWS*MAX_COLS
// cells, one per cycle, with full held high; configuration writes are taken meanwhile.
// When the receiver stalls, results wait in a 2-entry result queue and the engine
// stops dispatching once that queue is full.
module text_console_writer_top #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 128,
    parameter int TAB_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [12:0] i_cell_address,
    output logic        empty,
    input  logic        pop,
    output logic [12:0] o_cursor_position,
    output logic [6:0]  o_cursor_column,
    output logic [5:0]  o_cursor_row,
    output logic        o_scrolled,
    output logic [15:0] o_read_cell
);

    localparam int CMD_W = $bits(tcw_pkg::t_cmd);
    localparam int RES_W = $bits(tcw_pkg::t_res);

    tcw_pkg::t_cfg  r_cfg;
    logic           cfg_wr;

    tcw_pkg::t_cmd  front_cmd;
    logic           front_push;
    logic           cmd_full;
    logic           cmd_empty;
    logic [CMD_W-1:0] cmd_q;
    logic           cmd_pop;
    logic           init_busy;

    tcw_pkg::t_res  back_res;
    logic           res_push;
    logic           res_full;
    logic [RES_W-1:0] res_q;
    tcw_pkg::t_res  res_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows <= tcw_pkg::RESET_ROWS;
            r_cfg.cols <= tcw_pkg::RESET_COLS;
            r_cfg.attr <= tcw_pkg::RESET_ATTR;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tcw_pkg::REG_ROWS: r_cfg.rows <= pwdata[6:0];
                tcw_pkg::REG_COLS: r_cfg.cols <= pwdata[7:0];
                tcw_pkg::REG_ATTR: r_cfg.attr <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tcw_pkg::REG_ROWS: prdata = {25'd0, r_cfg.rows};
            tcw_pkg::REG_COLS: prdata = {24'd0, r_cfg.cols};
            tcw_pkg::REG_ATTR: prdata = {24'd0, r_cfg.attr};
            default:           prdata = '0;
        endcase
    end

    tcw_front #(
        .STORE_DEPTH (MAX_ROWS * MAX_COLS)
    ) u_front (
        .i_push         (push),
        .i_opcode       (i_opcode),
        .i_char_code    (i_char_code),
        .i_cell_address (i_cell_address),
        .i_init_busy    (init_busy),
        .i_cmd_full     (cmd_full),
        .o_full         (full),
        .o_cmd_push     (front_push),
        .o_cmd          (front_cmd)
    );

    tcw_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (tcw_pkg::QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_q),
        .o_empty (cmd_empty)
    );

    tcw_back #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (tcw_pkg::t_cmd'(cmd_q)),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res),
        .o_init_busy (init_busy)
    );

    tcw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (tcw_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out           = tcw_pkg::t_res'(res_q);
    assign o_cursor_position = res_out.cursor_position;
    assign o_cursor_column   = res_out.cursor_column;
    assign o_cursor_row      = res_out.cursor_row;
    assign o_scrolled        = res_out.scrolled;
    assign o_read_cell       = res_out.read_cell;

endmodule

// File: verif/testbench.sv
// testbench: self-checking bench for the text console writer
// depends on tcw_pkg and text_console_writer_top; keeps its own screen copy and cursor
`timescale 1ns / 1ps

module testbench;

    localparam int SCREEN_ROWS_MAX = 64;
    localparam int SCREEN_COLS_MAX = 128;
    localparam int TAB_STOP        = 8;
    localparam int STORE_CELLS     = SCREEN_ROWS_MAX * SCREEN_COLS_MAX;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_REPORTS     = 100;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]    op;
        logic [7:0]    char_code;
        logic [12:0]   cell_address;
        logic          typed;
        tcw_pkg::t_res result;
    } t_directed_row;

    typedef struct packed {
        logic [6:0]  rows;
        logic [7:0]  cols;
        logic [7:0]  attr;
        logic [15:0] items;
        logic        stress;
        logic        pause;
        logic        shuffle;
    } t_phase;

    // reset geometry is 25 x 80 with attribute 0x0f
    localparam t_directed_row DIRECTED_ITEMS [0:19] = '{
        {tcw_pkg::OP_READ, 8'h00, 13'd0, 1'b1, 13'd0, 7'd0, 6'd0, 1'b0, tcw_pkg::RESET_CELL},
        {tcw_pkg::OP_READ, 8'hFF, 13'h1FFF, 1'b1, 13'd0, 7'd0, 6'd0, 1'b0, tcw_pkg::RESET_CELL},
        {tcw_pkg::OP_PUT,  8'h41, 13'd0, 1'b1, 13'd1, 7'd1, 6'd0, 1'b0, 16'h0000},
        {tcw_pkg::OP_READ, 8'h00, 13'd0, 1'b1, 13'd1, 7'd1, 6'd0, 1'b0, 16'h0F41},
        {tcw_pkg::OP_PUT,  tcw_pkg::CHAR_BS, 13'd0, 1'b1, 13'd0, 7'd0, 6'd0, 1'b0, 16'h0000},
        {tcw_pkg::OP_PUT,  tcw_pkg::CHAR_BS, 13'h1FFF, 1'b1, 13'd0, 7'd0, 6'd0, 1'b0, 16'h0000},
        {tcw_pkg::OP_PUT,  tcw_pkg::CHAR_TAB, 13'd0, 1'b1, 13'd8, 7'd8, 6'd0, 1'b0, 16'h0000},
        {tcw_pkg::OP_PUT,  tcw_pkg::CHAR_TAB, 13'd0, 1'b1, 13'd16, 7'd16, 6'd0, 1'b0, 16'h0000},
        {tcw_pkg::OP_PUT,  tcw_pkg::CHAR_NL, 13'd0, 1'b1, 13'd80, 7'd0, 6'd1, 1'b0, 16'h0000},
        {tcw_pkg::OP_PUT,  8'h00, 13'd0, 1'b1, 13'd80, 7'd0, 6'd1, 1'b0, 16'h0000},
        {tcw_pkg::OP_PUT,  8'h1F, 13'd0, 1'b1, 13'd80, 7'd0, 6'd1, 1'b0, 16'h0000},
        {tcw_pkg::OP_PUT,  8'hFF, 13'd0, 1'b1, 13'd81, 7'd1, 6'd1, 1'b0, 16'h0000},
        {tcw_pkg::OP_PUT,  tcw_pkg::CHAR_SPACE, 13'd0, 1'b1, 13'd82, 7'd2, 6'd1, 1'b0, 16'h0000},
        {tcw_pkg::OP_READ, 8'h00, 13'd80, 1'b1, 13'd82, 7'd2, 6'd1, 1'b0, 16'h0FFF},
        {OP_UNUSED,        8'hFF, 13'h1FFF, 1'b1, 13'd82, 7'd2, 6'd1, 1'b0, 16'h0000},
        {tcw_pkg::OP_CLEAR, 8'h00, 13'd0, 1'b1, 13'd0, 7'd0, 6'd0, 1'b0, 16'h0000},
        {tcw_pkg::OP_READ, 8'h00, 13'd80, 1'b1, 13'd0, 7'd0, 6'd0, 1'b0, tcw_pkg::RESET_CELL},
        {tcw_pkg::OP_PUT,  8'h7F, 13'd0, 1'b0, 43'd0},
        {tcw_pkg::OP_PUT,  8'h80, 13'h0AAA, 1'b0, 43'd0},
        {tcw_pkg::OP_READ, 8'h00, 13'd1, 1'b0, 43'd0}
    };

    // zero rows/cols act as 1, oversized ones act as the maximum
    localparam t_phase PHASES [0:11] = '{
        {7'd4,   8'd8,   8'h1E, 16'd100, 1'b1, 1'b0, 1'b0},
        {7'd1,   8'd1,   8'h00, 16'd60,  1'b0, 1'b0, 1'b0},
        {7'd0,   8'd0,   8'hFF, 16'd40,  1'b0, 1'b0, 1'b0},
        {7'd64,  8'd128, 8'h70, 16'd25,  1'b0, 1'b0, 1'b0},
        {7'd3,   8'd16,  8'hA5, 16'd120, 1'b0, 1'b1, 1'b0},
        {7'd127, 8'd255, 8'h5A, 16'd20,  1'b0, 1'b0, 1'b0},
        {7'd2,   8'd5,   8'h3C, 16'd100, 1'b0, 1'b0, 1'b0},
        {7'd8,   8'd10,  8'hC3, 16'd120, 1'b1, 1'b0, 1'b0},
        {7'd1,   8'd128, 8'h81, 16'd60,  1'b0, 1'b0, 1'b0},
        {7'd64,  8'd1,   8'h42, 16'd60,  1'b0, 1'b0, 1'b0},
        {7'd0,   8'd0,   8'h00, 16'd120, 1'b0, 1'b0, 1'b1},
        {7'd6,   8'd9,   8'h07, 16'd100, 1'b0, 1'b1, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_opcode = '0;
    logic [7:0]  i_char_code = '0;
    logic [12:0] i_cell_address = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [12:0] o_cursor_position;
    logic [6:0]  o_cursor_column;
    logic [5:0]  o_cursor_row;
    logic        o_scrolled;
    logic [15:0] o_read_cell;

    // local copy of the console
    logic [15:0] screen_mirror [0:STORE_CELLS-1];
    int          cursor_col;
    int          cursor_row;
    logic [6:0]  cfg_rows;
    logic [7:0]  cfg_cols;
    logic [7:0]  cfg_attr;

    tcw_pkg::t_res cursor_reports_due [$];
    int          error_count = 0;
    int          burst_left = 0;

    bit          hold_request = 1'b0;
    int          hold_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;
    tcw_pkg::t_res oldest_report;

    always #5 i_clk = ~i_clk;

    text_console_writer_top #(
        .MAX_ROWS  (SCREEN_ROWS_MAX),
        .MAX_COLS  (SCREEN_COLS_MAX),
        .TAB_WIDTH (TAB_STOP)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .push              (push),
        .full              (full),
        .i_opcode          (i_opcode),
        .i_char_code       (i_char_code),
        .i_cell_address    (i_cell_address),
        .empty             (empty),
        .pop               (pop),
        .o_cursor_position (o_cursor_position),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_row      (o_cursor_row),
        .o_scrolled        (o_scrolled),
        .o_read_cell       (o_read_cell)
    );

    function automatic int rows_used();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > SCREEN_ROWS_MAX) return SCREEN_ROWS_MAX;
        return cfg_rows;
    endfunction

    function automatic int cols_used();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > SCREEN_COLS_MAX) return SCREEN_COLS_MAX;
        return cfg_cols;
    endfunction

    task automatic blank_cells(input int from, input int upto);
        for (int i = from; i < upto && i < STORE_CELLS; i++) begin
            screen_mirror[i] = {cfg_attr, tcw_pkg::CHAR_SPACE};
        end
    endtask

    task automatic scroll_up(input int lines, input int rows, input int cols);
        int kept;
        if (lines >= rows) begin
            blank_cells(0, rows * cols);
        end else begin
            kept = (rows - lines) * cols;
            for (int i = 0; i < kept; i++) begin
                screen_mirror[i] = screen_mirror[i + lines * cols];
            end
            blank_cells(kept, rows * cols);
        end
    endtask

    task automatic console_step(input logic [1:0] op, input logic [7:0] ch,
                                input logic [12:0] addr, output tcw_pkg::t_res report);
        int         rows;
        int         cols;
        int         col;
        int         row;
        int         cell_index;
        logic       did_scroll;
        logic [15:0] cell_word;
        rows = rows_used();
        cols = cols_used();
        did_scroll = 1'b0;
        cell_word = '0;
        case (op)
            tcw_pkg::OP_PUT: begin
                col = cursor_col;
                row = cursor_row;
                if (ch == tcw_pkg::CHAR_BS) begin
                    if (col > 0) col--;
                end else if (ch == tcw_pkg::CHAR_TAB) begin
                    col = col + TAB_STOP - (col % TAB_STOP);
                end else if (ch == tcw_pkg::CHAR_NL) begin
                    col = 0;
                    row++;
                end else if (ch >= tcw_pkg::CHAR_SPACE) begin
                    // a cursor left outside a shrunk screen may point past the store
                    cell_index = row * cols + col;
                    if (cell_index < STORE_CELLS) screen_mirror[cell_index] = {cfg_attr, ch};
                    col++;
                end
                if (col >= cols) begin
                    col = 0;
                    row++;
                end
                if (row >= rows) begin
                    scroll_up(row - rows + 1, rows, cols);
                    row = rows - 1;
                    did_scroll = 1'b1;
                end
                cursor_col = col;
                cursor_row = row;
            end
            tcw_pkg::OP_CLEAR: begin
                blank_cells(0, rows * cols);
                cursor_col = 0;
                cursor_row = 0;
            end
            tcw_pkg::OP_READ: begin
                cell_word = screen_mirror[addr];
            end
            default: begin
            end
        endcase
        report.cursor_position = 13'(cursor_row * cols + cursor_col);
        report.cursor_column   = 7'(cursor_col);
        report.cursor_row      = 6'(cursor_row);
        report.scrolled        = did_scroll;
        report.read_cell       = cell_word;
    endtask

    task automatic apb_write(input logic [1:0] reg_index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_index)
            tcw_pkg::REG_ROWS: cfg_rows = value[6:0];
            tcw_pkg::REG_COLS: cfg_cols = value[7:0];
            tcw_pkg::REG_ATTR: cfg_attr = value[7:0];
            default: begin
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [12:0] addr, input bit typed,
                             input tcw_pkg::t_res typed_report);
        tcw_pkg::t_res predicted;
        i_opcode       <= op;
        i_char_code    <= ch;
        i_cell_address <= addr;
        push           <= 1'b1;
        do @(posedge i_clk); while (full);
        console_step(op, ch, addr, predicted);
        cursor_reports_due.push_back(typed ? typed_report : predicted);
    endtask

    // bursts of random length with random gaps, unless held steady
    task automatic pace_sender(input bit steady);
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 12);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (cursor_reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_item(output logic [1:0] op, output logic [7:0] ch,
                               output logic [12:0] addr);
        int pick;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        addr = 13'($urandom_range(0, STORE_CELLS - 1));
        op   = tcw_pkg::OP_PUT;
        if (pick < 55) begin
            ch = 8'($urandom_range(32, 255));
        end else if (pick < 63) begin
            ch = tcw_pkg::CHAR_NL;
        end else if (pick < 68) begin
            ch = tcw_pkg::CHAR_TAB;
        end else if (pick < 73) begin
            ch = tcw_pkg::CHAR_BS;
        end else if (pick < 78) begin
            ch = 8'($urandom_range(0, 31));
        end else if (pick < 92) begin
            op = tcw_pkg::OP_READ;
            // mostly cells of the visible screen
            if ($urandom_range(0, 2) != 0) addr = 13'($urandom_range(0, rows_used() * cols_used() - 1));
        end else if (pick < 96) begin
            op = tcw_pkg::OP_CLEAR;
        end else begin
            op = OP_UNUSED;
        end
    endtask

    task automatic compare_field(input string field_name, input int want, input int got);
        if (want != got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, field_name, want, got);
        end
    endtask

    // result side: check accepted items, then choose pop for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (cursor_reports_due.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result item with none expected, position 0x%0h cell 0x%0h",
                             $time, o_cursor_position, o_read_cell);
            end else begin
                oldest_report = cursor_reports_due.pop_front();
                compare_field("cursor_position", oldest_report.cursor_position, o_cursor_position);
                compare_field("cursor_column", oldest_report.cursor_column, o_cursor_column);
                compare_field("cursor_row", oldest_report.cursor_row, o_cursor_row);
                compare_field("scrolled", oldest_report.scrolled, o_scrolled);
                compare_field("read_cell", oldest_report.read_cell, o_read_cell);
            end
        end
        if (hold_request && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        t_phase      ph;
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [12:0] addr;
        for (int i = 0; i < STORE_CELLS; i++) screen_mirror[i] = tcw_pkg::RESET_CELL;
        cursor_col = 0;
        cursor_row = 0;
        cfg_rows = tcw_pkg::RESET_ROWS;
        cfg_cols = tcw_pkg::RESET_COLS;
        cfg_attr = tcw_pkg::RESET_ATTR;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < $size(DIRECTED_ITEMS); k++) begin
            send_item(DIRECTED_ITEMS[k].op, DIRECTED_ITEMS[k].char_code,
                      DIRECTED_ITEMS[k].cell_address, DIRECTED_ITEMS[k].typed,
                      DIRECTED_ITEMS[k].result);
            pace_sender(1'b0);
        end

        for (int p = 0; p < $size(PHASES); p++) begin
            ph = PHASES[p];
            drain();
            if (ph.shuffle) begin
                ph.rows = 7'($urandom_range(1, 8));
                ph.cols = 8'($urandom_range(1, 20));
                ph.attr = 8'($urandom_range(0, 255));
            end
            // upper data bits are random, the register keeps only its width
            apb_write(tcw_pkg::REG_ROWS, ($urandom() & 32'hFFFF_FF80) | ph.rows);
            apb_write(tcw_pkg::REG_COLS, ($urandom() & 32'hFFFF_FF00) | ph.cols);
            apb_write(tcw_pkg::REG_ATTR, ($urandom() & 32'hFFFF_FF00) | ph.attr);
            apb_write(REG_UNUSED, $urandom());
            if (ph.stress) hold_request = 1'b1;
            for (int n = 0; n < ph.items; n++) begin
                if (ph.pause && n == ph.items / 2) drain();
                random_item(op, ch, addr);
                send_item(op, ch, addr, 1'b0, '0);
                pace_sender(ph.stress);
            end
        end

        drain();
        if (error_count == 0) begin
            $display("text_console_writer_top regression: pass");
        end else begin
            $display("text_console_writer_top regression: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("text_console_writer_top regression: fail");
        $finish;
    end

endmodule
